/* rtl/mrwt_pkg.sv */
// ----------------------------------------------------------------------------
// mrwt_pkg: shared definitions of the witness round
// Default operand width and the status bundle of the modular multiplier.
// ----------------------------------------------------------------------------
package mrwt_pkg;

   localparam int NUMBER_BITS_DEFAULT = 31;

   typedef struct packed {
      logic busy;
      logic done;
   } mrwt_mm_stat_type;

endpackage

/* rtl/mrwt_if.sv */
// ----------------------------------------------------------------------------
// mrwt_if: item channels of the witness round
// Request channel (candidate, witness) and response channel (verdict).
// ----------------------------------------------------------------------------
interface mrwt_req_if #(
   parameter int NUMBER_BITS = mrwt_pkg::NUMBER_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [NUMBER_BITS-1:0] candidate;
   logic [NUMBER_BITS-1:0] witness;

   modport source (output valid, candidate, witness, input ready);
   modport sink   (input valid, candidate, witness, output ready);
endinterface

interface mrwt_rsp_if;
   logic valid;
   logic ready;
   logic probable_prime;

   modport source (output valid, probable_prime, input ready);
   modport sink   (input valid, probable_prime, output ready);
endinterface

/* rtl/mrwt_mulmod.sv */
// ----------------------------------------------------------------------------
// mrwt_mulmod: bit-serial modular multiplier
// Computes (a * b) mod n by shift and add, one bit of b per cycle, a < n.
// ----------------------------------------------------------------------------
module mrwt_mulmod #(
   parameter int NUMBER_BITS = mrwt_pkg::NUMBER_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUMBER_BITS-1:0]     a,
   input  logic [NUMBER_BITS-1:0]     b,
   input  logic [NUMBER_BITS-1:0]     n,
   output logic [NUMBER_BITS-1:0]     result,
   output mrwt_pkg::mrwt_mm_stat_type stat
);

   localparam int CW = $clog2(NUMBER_BITS + 1);

   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic [NUMBER_BITS-1:0] addend_ff, addend_in;
   logic [NUMBER_BITS-1:0] b_ff, b_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [NUMBER_BITS:0] acc_sum;
   logic [NUMBER_BITS:0] addend_dbl;
   logic [NUMBER_BITS:0] n_ext;

   assign n_ext      = {1'b0, n};
   assign acc_sum    = {1'b0, acc_ff} + {1'b0, addend_ff};
   assign addend_dbl = {addend_ff, 1'b0};

   always_comb begin
      acc_in    = acc_ff;
      addend_in = addend_ff;
      b_in      = b_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         addend_in = a;
         b_in      = b;
         cnt_in    = CW'(NUMBER_BITS);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            // both terms below n, so one subtraction keeps the sum reduced
            acc_in = (acc_sum >= n_ext) ? NUMBER_BITS'(acc_sum - n_ext)
                                        : NUMBER_BITS'(acc_sum);
         end
         addend_in = (addend_dbl >= n_ext) ? NUMBER_BITS'(addend_dbl - n_ext)
                                           : NUMBER_BITS'(addend_dbl);
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      addend_ff <= addend_in;
      b_ff      <= b_in;
   end

   assign result    = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/miller_rabin_witness_test.sv */
// ----------------------------------------------------------------------------
// miller_rabin_witness_test: one Miller-Rabin round per item
// Takes a candidate and a witness, returns whether the candidate passes.
// ----------------------------------------------------------------------------
// One item at a time. Candidates below two and even candidates are answered
// directly, two as prime. An odd candidate first strips the r factors of two
// from candidate minus one, then every modular product goes through one
// bit-serial multiplier: one product to reduce the witness, NUMBER_BITS
// squarings plus one product per set bit of the odd part, and up to r - 1
// further squarings. The time per item is set by the multiplier's one bit
// per cycle. A finished verdict waits in the output register while the next
// item is taken.
module miller_rabin_witness_test #(
   parameter int NUMBER_BITS = mrwt_pkg::NUMBER_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   mrwt_req_if.sink   req_chan,
   mrwt_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(NUMBER_BITS + 1);
   localparam int RW = $clog2(NUMBER_BITS);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_STRIP   = 3'd1;
   localparam logic [2:0] ST_REDUCE  = 3'd2;
   localparam logic [2:0] ST_POW_SQ  = 3'd3;
   localparam logic [2:0] ST_POW_MUL = 3'd4;
   localparam logic [2:0] ST_CHECK   = 3'd5;
   localparam logic [2:0] ST_LOOP    = 3'd6;
   localparam logic [2:0] ST_PUT     = 3'd7;

   localparam logic [NUMBER_BITS-1:0] ONE = NUMBER_BITS'(1);

   logic [2:0]             state_ff, state_in;
   logic [NUMBER_BITS-1:0] n_ff, n_in;
   logic [NUMBER_BITS-1:0] nm1_ff, nm1_in;
   logic [NUMBER_BITS-1:0] w_ff, w_in;
   logic [NUMBER_BITS-1:0] e_ff, e_in;
   logic [NUMBER_BITS-1:0] wr_ff, wr_in;
   logic [NUMBER_BITS-1:0] res_ff, res_in;
   logic [RW-1:0]          r_ff, r_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   verdict_ff, verdict_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_bit_ff, rsp_bit_in;

   logic                       mm_start;
   logic [NUMBER_BITS-1:0]     mm_a;
   logic [NUMBER_BITS-1:0]     mm_b;
   logic [NUMBER_BITS-1:0]     mm_result;
   mrwt_pkg::mrwt_mm_stat_type mm_stat;
   logic                       accept;

   mrwt_mulmod #(.NUMBER_BITS(NUMBER_BITS)) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mm_start),
      .a      (mm_a),
      .b      (mm_b),
      .n      (n_ff),
      .result (mm_result),
      .stat   (mm_stat)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      nm1_in       = nm1_ff;
      w_in         = w_ff;
      e_in         = e_ff;
      wr_in        = wr_ff;
      res_in       = res_ff;
      r_in         = r_ff;
      cnt_in       = cnt_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_bit_in   = rsp_bit_ff;
      mm_start     = 1'b0;
      mm_a         = mm_result;
      mm_b         = mm_result;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in   = req_chan.candidate;
               w_in   = req_chan.witness;
               nm1_in = req_chan.candidate - ONE;
               e_in   = req_chan.candidate - ONE;
               r_in   = '0;
               if (req_chan.candidate[NUMBER_BITS-1:1] == '0) begin
                  verdict_in = 1'b0;
                  state_in   = ST_PUT;
               end else if (req_chan.candidate == NUMBER_BITS'(2)) begin
                  verdict_in = 1'b1;
                  state_in   = ST_PUT;
               end else if (!req_chan.candidate[0]) begin
                  verdict_in = 1'b0;
                  state_in   = ST_PUT;
               end else begin
                  state_in = ST_STRIP;
               end
            end
         end
         ST_STRIP: begin
            if (!e_ff[0]) begin
               e_in = e_ff >> 1;
               r_in = r_ff + RW'(1);
            end else begin
               // witness mod candidate as 1 * witness
               mm_start = 1'b1;
               mm_a     = ONE;
               mm_b     = w_ff;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mm_stat.done) begin
               wr_in    = mm_result;
               cnt_in   = CW'(NUMBER_BITS);
               mm_start = 1'b1;
               mm_a     = ONE;
               mm_b     = ONE;
               state_in = ST_POW_SQ;
            end
         end
         ST_POW_SQ: begin
            if (mm_stat.done) begin
               res_in = mm_result;
               if (e_ff[NUMBER_BITS-1]) begin
                  mm_start = 1'b1;
                  mm_b     = wr_ff;
                  state_in = ST_POW_MUL;
               end else begin
                  e_in = e_ff << 1;
                  if (cnt_ff == CW'(1)) begin
                     state_in = ST_CHECK;
                  end else begin
                     cnt_in   = cnt_ff - CW'(1);
                     mm_start = 1'b1;
                  end
               end
            end
         end
         ST_POW_MUL: begin
            if (mm_stat.done) begin
               res_in = mm_result;
               e_in   = e_ff << 1;
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_CHECK;
               end else begin
                  cnt_in   = cnt_ff - CW'(1);
                  mm_start = 1'b1;
                  state_in = ST_POW_SQ;
               end
            end
         end
         ST_CHECK: begin
            if (res_ff == ONE || res_ff == nm1_ff) begin
               verdict_in = 1'b1;
               state_in   = ST_PUT;
            end else if (r_ff == RW'(1)) begin
               verdict_in = 1'b0;
               state_in   = ST_PUT;
            end else begin
               r_in     = r_ff - RW'(1);
               mm_start = 1'b1;
               mm_a     = res_ff;
               mm_b     = res_ff;
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (mm_stat.done) begin
               if (mm_result == nm1_ff) begin
                  verdict_in = 1'b1;
                  state_in   = ST_PUT;
               end else if (mm_result == ONE || r_ff == RW'(1)) begin
                  verdict_in = 1'b0;
                  state_in   = ST_PUT;
               end else begin
                  r_in     = r_ff - RW'(1);
                  mm_start = 1'b1;
               end
            end
         end
         ST_PUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = verdict_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff       <= n_in;
      nm1_ff     <= nm1_in;
      w_ff       <= w_in;
      e_ff       <= e_in;
      wr_ff      <= wr_in;
      res_ff     <= res_in;
      r_ff       <= r_in;
      cnt_ff     <= cnt_in;
      verdict_ff <= verdict_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.probable_prime = rsp_bit_ff;

   // multiplier is only started when free
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      mm_start |-> !mm_stat.busy)
      else $error("multiplier started while busy");

   // completion follows a busy cycle
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      mm_stat.done |-> $past(mm_stat.busy))
      else $error("multiplier done without work");

   // power result stays reduced
   a_res_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (res_ff < n_ff))
      else $error("unreduced power result");

   // a new item is never taken while the multiplier still works
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      accept |-> !mm_stat.busy)
      else $error("item accepted during multiplication");

endmodule
